>>> rtl/fractional_rate_resampler_assert.svh
// Assertion macros for the resampler; clk_i and rst_ni are taken from the
// module that uses them.
`ifndef FRACTIONAL_RATE_RESAMPLER_ASSERT_SVH
`define FRACTIONAL_RATE_RESAMPLER_ASSERT_SVH

// Same-cycle implication
`define FRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// Shared codes, fixed widths and types of the fractional rate resampler.
// ----------------------------------------------------------------------------
package frr_pkg;

  // Fixed field widths
  localparam int RateW   = 24;
  localparam int InvW    = 32;
  localparam int PhaseInW = 20;
  localparam int InterpBits = 20;

  // Request actions
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_PHASE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_RATE = 2'd0;
  localparam logic [1:0] REG_INV  = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  // Interpolation modes
  localparam logic MODE_LINEAR  = 1'b0;
  localparam logic MODE_HERMITE = 1'b1;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [InvW-1:0]  inv;
    logic             mode;
  } frr_cfg_t;

endpackage

>>> rtl/frr_fifo.sv
// ----------------------------------------------------------------------------
// frr_fifo
// Small register queue with combinational head read.
// ----------------------------------------------------------------------------
module frr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

>>> rtl/frr_front.sv
// ----------------------------------------------------------------------------
// frr_front
// Accepts requests, keeps history and phase, and issues interpolation jobs.
// ----------------------------------------------------------------------------
module frr_front import frr_pkg::*; #(
  parameter int MaxOutputs    = 16,
  parameter int SampleWidth   = 24,
  parameter int PhaseFracBits = 20,
  parameter int CntW          = 5,
  parameter int JobW          = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  frr_cfg_t               cfg_i,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             action_i,
  input  logic [SampleWidth-1:0] sample_in_i,
  input  logic [PhaseInW-1:0]    phase_value_i,
  output logic                   job_push_o,
  output logic [JobW-1:0]        job_data_o,
  input  logic                   job_full_i
);
  localparam int W   = SampleWidth;
  localparam int P   = PhaseFracBits;
  localparam int FW  = P + 1;
  localparam int PSW = ((P > RateW) ? P : RateW) + 1;
  localparam int MW  = FW + InvW;
  localparam logic [FW-1:0] F_ONE = {1'b1, {P{1'b0}}};

  logic [W-1:0]    hist_q [4];
  logic [1:0]      newest_q;
  logic [P-1:0]    phase_q;
  logic            pend_q;
  logic [MW-1:0]   prod_q;
  logic [CntW-1:0] n_q;
  logic [4*W-1:0]  ys_q;

  logic            accept;
  logic [1:0]      idx_new, idx_y0, idx_y1;
  logic [PSW-1:0]  psum, whole;
  logic [CntW-1:0] n_d;
  logic [FW-1:0]   diff, base;
  logic [MW-1:0]   bsh;

  assign full       = pend_q;
  assign accept     = push && !pend_q;
  assign idx_new    = newest_q + 2'd1;
  assign idx_y0     = newest_q + 2'd2;
  assign idx_y1     = newest_q + 2'd3;
  assign psum       = PSW'(phase_q) + PSW'(cfg_i.rate);
  assign whole      = psum >> P;
  assign n_d        = (whole > PSW'(MaxOutputs)) ? CntW'(MaxOutputs) : CntW'(whole);
  assign diff       = F_ONE - FW'(phase_q);
  assign bsh        = prod_q >> P;
  assign base       = (bsh > MW'(F_ONE)) ? F_ONE : bsh[FW-1:0];
  assign job_push_o = pend_q && !job_full_i;
  assign job_data_o = {n_q, base, ys_q};

  // Hold job operands
  always_ff @(posedge clk_i) begin
    if (accept && action_i == ACT_PUSH) begin
      prod_q <= MW'(diff) * MW'(cfg_i.inv);
      n_q    <= n_d;
      ys_q   <= {sample_in_i, hist_q[newest_q], hist_q[idx_y1], hist_q[idx_y0]};
    end
  end

  // Update history, phase and pending job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= '0;
      end
      newest_q <= '0;
      phase_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      if (job_push_o) begin
        pend_q <= 1'b0;
      end
      if (accept) begin
        unique case (action_i)
          ACT_PUSH: begin
            newest_q        <= idx_new;
            hist_q[idx_new] <= sample_in_i;
            phase_q         <= psum[P-1:0];
            pend_q          <= (n_d != '0);
          end
          ACT_PHASE: begin
            phase_q <= P'(phase_value_i);
          end
          ACT_CLEAR: begin
            for (int i = 0; i < 4; i++) begin
              hist_q[i] <= '0;
            end
            newest_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

>>> rtl/frr_back.sv
// ----------------------------------------------------------------------------
// frr_back
// Runs each job: steps the fraction and evaluates one output at a time.
// ----------------------------------------------------------------------------
module frr_back import frr_pkg::*; #(
  parameter int SampleWidth   = 24,
  parameter int PhaseFracBits = 20,
  parameter int CntW          = 5,
  parameter int JobW          = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frr_cfg_t             cfg_i,
  input  logic                 job_empty_i,
  input  logic [JobW-1:0]      job_data_i,
  output logic                 job_pop_o,
  output logic                 res_push_o,
  output logic [SampleWidth:0] res_data_o,
  input  logic                 res_full_i
);
  localparam int W    = SampleWidth;
  localparam int P    = PhaseFracBits;
  localparam int FW   = P + 1;
  localparam int AW   = W + 6;
  localparam int PRW  = AW + InterpBits + 2;
  localparam int SH_R = (P >= InterpBits) ? P - InterpBits : 0;
  localparam int SH_L = (P >= InterpBits) ? 0 : InterpBits - P;
  localparam int FXW  = FW + SH_L;
  localparam int FSW  = ((FW > InvW) ? FW : InvW) + 1;
  localparam logic [FW-1:0] F_ONE = {1'b1, {P{1'b0}}};
  localparam logic signed [AW-1:0] SMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN = ~SMAX;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state_q;
  logic [1:0]             step_q;
  logic [CntW-1:0]        cnt_q;
  logic [FW-1:0]          f_q;
  logic signed [AW-1:0]   acc_q, init_q;
  logic signed [AW-1:0]   add_q [3];
  logic signed [PRW-1:0]  prod_q;

  logic [W-1:0]           y0, y1, y2, y3;
  logic signed [AW-1:0]   e0, e1, e2, e3, d12;
  logic signed [AW-1:0]   init_d, add0_d, add1_d, add2_d;
  logic [CntW-1:0]        job_n;
  logic [FW-1:0]          job_base;
  logic [FXW-1:0]         fx;
  logic [InterpBits:0]    fi;
  logic signed [PRW-1:0]  sh;
  logic [FSW-1:0]         fsum;
  logic signed [AW-1:0]   res;
  logic [W-1:0]           sat;
  logic [1:0]             last_step;

  assign {job_n, job_base, y3, y2, y1, y0} = job_data_i;

  // Form coefficients from the job's four samples
  assign e0  = AW'($signed(y0));
  assign e1  = AW'($signed(y1));
  assign e2  = AW'($signed(y2));
  assign e3  = AW'($signed(y3));
  assign d12 = e1 - e2;
  always_comb begin
    if (cfg_i.mode == MODE_HERMITE) begin
      init_d = (e3 - e0) + (d12 <<< 1) + d12;
      add0_d = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      add1_d = e2 - e0;
      add2_d = e1 <<< 1;
    end else begin
      init_d = e3 - e2;
      add0_d = e2;
      add1_d = '0;
      add2_d = '0;
    end
  end

  // Bring the fraction to the interpolator's scale
  assign fx        = (FXW'(f_q) << SH_L) >> SH_R;
  assign fi        = fx[InterpBits:0];
  assign sh        = prod_q >>> InterpBits;
  assign fsum      = FSW'(f_q) + FSW'(cfg_i.inv);
  assign last_step = (cfg_i.mode == MODE_HERMITE) ? 2'd2 : 2'd0;

  // Halve the Hermite sum and saturate
  assign res = (cfg_i.mode == MODE_HERMITE) ? (acc_q >>> 1) : acc_q;
  always_comb begin
    priority if (res > SMAX) begin
      sat = SMAX[W-1:0];
    end else if (res < SMIN) begin
      sat = SMIN[W-1:0];
    end else begin
      sat = res[W-1:0];
    end
  end

  assign job_pop_o  = (state_q == ST_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == ST_EMIT) && !res_full_i;
  assign res_data_o = {sat, cnt_q == CntW'(1)};

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (job_pop_o) begin
          init_q   <= init_d;
          add_q[0] <= add0_d;
          add_q[1] <= add1_d;
          add_q[2] <= add2_d;
          acc_q    <= init_d;
          f_q      <= job_base;
        end
      end
      ST_MUL: begin
        prod_q <= acc_q * $signed({1'b0, fi});
      end
      ST_ADD: begin
        acc_q <= $signed(sh[AW-1:0]) + add_q[step_q];
      end
      ST_EMIT: begin
        if (res_push_o) begin
          acc_q <= init_q;
          f_q   <= (fsum > FSW'(F_ONE)) ? F_ONE : fsum[FW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence the steps of each output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (job_pop_o) begin
            cnt_q   <= job_n;
            step_q  <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (step_q == last_step) begin
            state_q <= ST_EMIT;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (res_push_o) begin
            cnt_q   <= cnt_q - 1'b1;
            step_q  <= '0;
            state_q <= (cnt_q == CntW'(1)) ? ST_IDLE : ST_MUL;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

>>> rtl/fractional_rate_resampler.sv
// Fractional rate resampler. Each push request stores a sample, adds the rate
// to the phase and yields zero to MAX_OUTPUTS interpolated outputs, the last
// one flagged by last_of_run_o; set-phase and clear requests yield none. The
// front end takes one request a cycle while no job is pending; a push that
// yields outputs registers the start-fraction product and holds full until
// the job is handed on to the job queue. The back end evaluates outputs one
// at a time through a single shared multiplier, stepping multiply and add
// states once in linear mode and once per added coefficient in Hermite mode,
// then an emit state. A two-entry job queue and a two-entry result queue let
// both sides stall independently.
// ----------------------------------------------------------------------------
// fractional_rate_resampler
// Top level: configuration registers, front end, job queue, back end, results.
// ----------------------------------------------------------------------------
`include "fractional_rate_resampler_assert.svh"

module fractional_rate_resampler import frr_pkg::*; #(
  parameter int MAX_OUTPUTS     = 16,
  parameter int SAMPLE_WIDTH    = 24,
  parameter int PHASE_FRAC_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [InvW-1:0]         cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              action_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic [PhaseInW-1:0]     phase_value_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                    last_of_run_o
);
  localparam int CntW = $clog2(MAX_OUTPUTS + 1);
  localparam int JobW = CntW + PHASE_FRAC_BITS + 1 + 4 * SAMPLE_WIDTH;

  frr_cfg_t              cfg_q;
  logic                  job_push, job_full, job_pop, job_empty;
  logic [JobW-1:0]       job_wdata, job_rdata;
  logic                  res_push, res_full;
  logic [SAMPLE_WIDTH:0] res_wdata, res_rdata;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate <= RateW'(1048576);
      cfg_q.inv  <= InvW'(1048576);
      cfg_q.mode <= MODE_HERMITE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RATE: cfg_q.rate <= cfg_wdata_i[RateW-1:0];
        REG_INV:  cfg_q.inv  <= cfg_wdata_i;
        REG_MODE: cfg_q.mode <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  frr_front #(
    .MaxOutputs   (MAX_OUTPUTS),
    .SampleWidth  (SAMPLE_WIDTH),
    .PhaseFracBits(PHASE_FRAC_BITS),
    .CntW         (CntW),
    .JobW         (JobW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .sample_in_i  (sample_in_i),
    .phase_value_i(phase_value_i),
    .job_push_o   (job_push),
    .job_data_o   (job_wdata),
    .job_full_i   (job_full)
  );

  frr_fifo #(.Width(JobW), .Depth(2)) u_job_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_push),
    .wr_data_i(job_wdata),
    .full_o   (job_full),
    .rd_en_i  (job_pop),
    .rd_data_o(job_rdata),
    .empty_o  (job_empty)
  );

  frr_back #(
    .SampleWidth  (SAMPLE_WIDTH),
    .PhaseFracBits(PHASE_FRAC_BITS),
    .CntW         (CntW),
    .JobW         (JobW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_empty_i(job_empty),
    .job_data_i (job_rdata),
    .job_pop_o  (job_pop),
    .res_push_o (res_push),
    .res_data_o (res_wdata),
    .res_full_i (res_full)
  );

  frr_fifo #(.Width(SAMPLE_WIDTH + 1), .Depth(2)) u_res_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (res_push),
    .wr_data_i(res_wdata),
    .full_o   (res_full),
    .rd_en_i  (pop),
    .rd_data_o(res_rdata),
    .empty_o  (empty)
  );

  assign sample_out_o  = res_rdata[SAMPLE_WIDTH:1];
  assign last_of_run_o = res_rdata[0];

  // Checks
  `FRR_ASSERT_NOW(a_job_no_overflow, job_push, !job_full, "job pushed into full queue")
  `FRR_ASSERT_NOW(a_res_no_overflow, res_push, !res_full, "result pushed into full queue")
  `FRR_ASSERT_NEXT(a_ctrl_no_stall, push && !full && action_i != ACT_PUSH, !full,
    "non-sample request stalled the front end")
endmodule

>>> tb/sv/fractional_rate_resampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_rate_resampler_tb
// Self-checking bench for the resampler. A scoreboard model predicts every
// interpolated output from each accepted request, and a clocked monitor
// compares each popped output against it. The run covers several rate,
// inverse-rate and interpolation settings, random gaps on both sides and
// one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module fractional_rate_resampler_tb;
  import frr_pkg::*;

  localparam int    MaxOut  = 16;
  localparam int    SampleW = 24;
  localparam int    FracW   = 20;
  localparam longint OnePhase = 64'd1 << FracW;
  localparam int    DrainCycles = 300;

  typedef struct {
    logic [1:0]         act;
    logic [SampleW-1:0] smp;
    logic [FracW-1:0]   ph;
  } request_t;

  typedef struct {
    logic [SampleW-1:0] smp;
    logic               last;
  } output_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [InvW-1:0] cfg_wdata_i = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] action_i = '0;
  logic [SampleW-1:0] sample_in_i = '0;
  logic [PhaseInW-1:0] phase_value_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [SampleW-1:0] sample_out_o;
  logic last_of_run_o;

  fractional_rate_resampler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .action_i, .sample_in_i, .phase_value_i,
    .empty, .pop, .sample_out_o, .last_of_run_o
  );

  // Model state and registers
  longint          hist [4];
  int              newest;
  longint unsigned phase_acc;
  longint unsigned rate_q;
  longint unsigned inv_q;
  logic            mode_q;

  request_t pending_reqs[$];
  output_t  expected_outs[$];
  int       errors = 0;
  int       send_idle = 0;
  int       recv_stall = 0;
  logic     hold_trig = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint saturate(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Interpolate at fraction f (Q1.20, 0..1.0)
  function automatic longint interpolate(longint f);
    longint y0, y1, y2, y3, c0, c1, c2, c3, acc;
    y0 = hist[(newest + 1) & 3];
    y1 = hist[(newest + 2) & 3];
    y2 = hist[(newest + 3) & 3];
    y3 = hist[newest];
    if (mode_q == MODE_LINEAR) return saturate(y2 + (((y3 - y2) * f) >>> FracW));
    c0 = 2 * y1;
    c1 = y2 - y0;
    c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    c3 = (y3 - y0) + 3 * (y1 - y2);
    acc = c3;
    acc = ((acc * f) >>> FracW) + c2;
    acc = ((acc * f) >>> FracW) + c1;
    acc = ((acc * f) >>> FracW) + c0;
    return saturate(acc >>> 1);
  endfunction

  // Advance the model by one request and queue the outputs it yields
  task automatic resample_request(request_t r);
    longint unsigned p, whole, base, f;
    int n;
    output_t o;
    if (r.act == ACT_PHASE) begin
      phase_acc = 64'(r.ph);
    end else if (r.act == ACT_CLEAR) begin
      foreach (hist[i]) hist[i] = 0;
      newest = 0;
    end else if (r.act == ACT_PUSH) begin
      newest = (newest + 1) & 3;
      hist[newest] = longint'($signed(r.smp));
      p = phase_acc + rate_q;
      whole = p >> FracW;
      n = (whole > MaxOut) ? MaxOut : int'(whole);
      base = ((OnePhase - phase_acc) * inv_q) >> FracW;
      for (int k = 0; k < n; k++) begin
        f = base + longint'(k) * inv_q;
        if (f > OnePhase) f = OnePhase;
        o.smp = SampleW'(interpolate(longint'(f)));
        o.last = (k + 1 == n);
        expected_outs.push_back(o);
      end
      phase_acc = p & (OnePhase - 1);
    end
  endtask

  // Drive requests from the pending queue; hold until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        resample_request(pending_reqs[0]);
        pending_reqs.pop_front();
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
        push <= 1'b1;
        action_i <= pending_reqs[0].act;
        sample_in_i <= pending_reqs[0].smp;
        phase_value_i <= pending_reqs[0].ph;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Count down a long output stall when triggered
  always @(posedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 2000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Pop and check outputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_outs.size() == 0) begin
          $display("%0t: unexpected output sample=%h last=%b", $time, sample_out_o,
                   last_of_run_o);
          errors++;
        end else begin
          if (sample_out_o !== expected_outs[0].smp) begin
            $display("%0t: sample_out expected %h actual %h", $time,
                     expected_outs[0].smp, sample_out_o);
            errors++;
          end
          if (last_of_run_o !== expected_outs[0].last) begin
            $display("%0t: last_of_run expected %b actual %b", $time,
                     expected_outs[0].last, last_of_run_o);
            errors++;
          end
          expected_outs.pop_front();
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [InvW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_RATE) rate_q = 64'(data[RateW-1:0]);
    else if (idx == REG_INV) inv_q = 64'(data);
    else if (idx == REG_MODE) mode_q = data[0];
  endtask

  task automatic configure(logic [RateW-1:0] r, logic [InvW-1:0] inv, logic m);
    write_reg(REG_RATE, InvW'(r));
    write_reg(REG_INV, inv);
    write_reg(REG_MODE, {31'd0, m});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic request_t mk(logic [1:0] a, logic [SampleW-1:0] s,
                                  logic [FracW-1:0] p);
    request_t r;
    r.act = a;
    r.smp = s;
    r.ph = p;
    return r;
  endfunction

  // Mostly pushes, with extremes, phase sets, clears and the unused action
  function automatic request_t random_request();
    int sel;
    logic [SampleW-1:0] s;
    sel = $urandom_range(99);
    case ($urandom_range(7))
      0: s = 24'h7FFFFF;
      1: s = 24'h800000;
      default: s = SampleW'($urandom);
    endcase
    if (sel < 86) return mk(ACT_PUSH, s, FracW'($urandom));
    if (sel < 93) begin
      return mk(ACT_PHASE, s, $urandom_range(3) == 0 ? 20'hFFFFF : FracW'($urandom));
    end
    if (sel < 97) return mk(ACT_CLEAR, s, FracW'($urandom));
    return mk(ACT_NONE, s, FracW'($urandom));
  endfunction

  task automatic run_phase(int count);
    repeat (count) pending_reqs.push_back(random_request());
    do @(posedge clk_i);
    while (pending_reqs.size() > 0 || push || expected_outs.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    longint unsigned r;
    foreach (hist[i]) hist[i] = 0;
    newest = 0;
    phase_acc = 0;
    rate_q = 64'd1048576;
    inv_q = 64'd1048576;
    mode_q = MODE_HERMITE;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: 4x upsampling, field extremes, every action
    configure(24'h400000, 32'h40000, MODE_HERMITE);
    pending_reqs.push_back(mk(ACT_PUSH, 24'h7FFFFF, '0));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h800000, '0));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h7FFFFF, 20'hFFFFF));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h800000, '0));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h000000, '0));
    pending_reqs.push_back(mk(ACT_PHASE, 24'hFFFFFF, 20'hFFFFF));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h123456, '0));
    pending_reqs.push_back(mk(ACT_PHASE, '0, '0));
    pending_reqs.push_back(mk(ACT_PUSH, 24'hEDCBA9, '0));
    pending_reqs.push_back(mk(ACT_CLEAR, 24'hFFFFFF, 20'hFFFFF));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h400000, '0));
    pending_reqs.push_back(mk(ACT_NONE, 24'hFFFFFF, 20'hFFFFF));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h7FFFFF, '0));
    pending_reqs.push_back(mk(ACT_PHASE, '0, 20'h80000));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h800000, '0));
    pending_reqs.push_back(mk(ACT_PUSH, 24'h000001, '0));
    run_phase(0);

    // Linear 1.5x, sender mostly idle
    configure(24'h180000, 32'd699050, MODE_LINEAR);
    send_idle = 88;
    run_phase(60);

    // Hermite 0.75x, receiver mostly stalled
    configure(24'h0C0000, 32'h155555, MODE_HERMITE);
    send_idle = 0;
    recv_stall = 88;
    run_phase(60);

    // Maximum rate, count saturates; long output stall backs up the input
    configure(24'hFFFFFF, 32'h10000, MODE_HERMITE);
    recv_stall = 0;
    hold_trig = ~hold_trig;
    run_phase(50);

    // Minimum rate with the largest inverse, linear
    configure(24'h000001, 32'hFFFFFFFF, MODE_LINEAR);
    send_idle = 11;
    recv_stall = 11;
    run_phase(40);

    // Rate and inverse zero
    configure('0, '0, MODE_HERMITE);
    run_phase(30);

    // Random settings around unity with inverse kept consistent
    repeat (3) begin
      r = 64'($urandom_range(24'h300000, 24'h080000));
      configure(RateW'(r), InvW'((64'd1 << 40) / r), 1'($urandom_range(1)));
      send_idle = ($urandom_range(1) == 0) ? 0 : 88;
      recv_stall = ($urandom_range(1) == 0) ? 0 : 88;
      run_phase(60);
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(20ns * 3_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
